[rtl/drse_pkg.sv]
// ----------------------------------------------------------------------------
// Row scan engine package
// Shared item and result types, scan sequencer states and the row code helper.
// ----------------------------------------------------------------------------
package drse_pkg;

  // Widths fixed by the item fields.
  localparam int ROW_W     = 4;
  localparam int COL_W     = 3;
  localparam int BYTE_W    = 8;
  localparam int MEM_AW    = ROW_W + COL_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // Widest row number (up to 99) and widest column count (up to 32).
  localparam int ROWNUM_W  = 7;
  localparam int COLNUM_W  = 5;

  // Divide by ten through a reciprocal, exact for values below 1029.
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [BYTE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_row_code;
    logic              last;
    logic              frame_end;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CODE
  } scan_state_t;

  // Row number as two BCD digits, tens in the upper nibble.
  function automatic logic [BYTE_W-1:0] row_bcd(input logic [ROWNUM_W-1:0] r);
    logic [17:0]         prod;
    logic [3:0]          tens;
    logic [ROWNUM_W-1:0] units;
    prod  = 18'(r) * 18'(DIV10_MUL);
    tens  = prod[DIV10_SHIFT+3:DIV10_SHIFT];
    units = r - ((ROWNUM_W'(tens) << 3) + (ROWNUM_W'(tens) << 1));
    return {tens, units[3:0]};
  endfunction

endpackage

[rtl/display_row_scan_engine_unit.sv]
// ----------------------------------------------------------------------------
// Display row scan engine
// Frame store plus a row scan sequencer that feeds a multiplexed display.
// ----------------------------------------------------------------------------
// A write transfer stores one pixel byte in the frame store and gives no result.
// A tick transfer scans the current row: it gives ROW_BYTES pixel results,
// from the last column down to column 0, and then the BCD row number marked
// last (the latch pulse), with frame_end set when the row counter wraps.
// item_ready stays low from a tick transfer until the row code is emitted.
// The single read port of the frame store shapes the scan: the first pixel
// needs the two highest columns, both read before it, then one pixel comes
// out per cycle while the result side is ready, with the reads running one
// column ahead, and a last step gives the row code.
// Only one item is in work at a time, but the engine takes the next item while
// the final result still sits in the output register. After reset the frame
// store reads as blank at once; no clearing pass is needed. Rows above 15 and
// columns above 7 cannot be written and always read as zero.
module display_row_scan_engine_unit #(
  parameter int ROW_BYTES = 8,
  parameter int LAST_ROW  = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  drse_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output drse_pkg::result_t result
);
  import drse_pkg::*;

  localparam int RW = (LAST_ROW > 1) ? $clog2(LAST_ROW + 1) : 1;
  localparam int CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
  localparam logic [RW-1:0]       LAST_ROW_R  = RW'(LAST_ROW);
  localparam logic [CW-1:0]       LAST_COL_C  = CW'(ROW_BYTES - 1);
  localparam logic [ROWNUM_W-1:0] LAST_ROW_N  = ROWNUM_W'(LAST_ROW);
  localparam logic [COLNUM_W-1:0] LAST_COL_N  = COLNUM_W'(ROW_BYTES - 1);
  localparam logic [ROWNUM_W-1:0] STORE_ROWS  = ROWNUM_W'(1 << ROW_W);
  localparam logic [COLNUM_W-1:0] STORE_COLS  = COLNUM_W'(1 << COL_W);

  // Frame store with one valid bit per entry so that reset blanks it at once.
  logic [BYTE_W-1:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] mem_vld;
  logic [BYTE_W-1:0]    mem_q;
  logic                 q_ok;
  logic                 q_vld;

  scan_state_t state, state_next;

  logic [RW-1:0]     scan_row;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     rd_col;
  logic [CW-1:0]     emit_col;
  logic              reads_left;
  logic              have_prev;
  logic [BYTE_W-1:0] prev;

  logic              tick_go;
  logic              wr_go;
  logic              out_free;
  logic [BYTE_W-1:0] q_data;
  logic              take_first;
  logic              consume;
  logic              issue;
  logic              emit_pix;
  logic              pix_done;
  logic              emit_code;
  logic [BYTE_W-1:0] pix_byte;
  logic              wrap;

  logic [ROWNUM_W-1:0] rd_row_n;
  logic [COLNUM_W-1:0] rd_col_n;
  logic [MEM_AW-1:0]   raddr;
  logic [MEM_AW-1:0]   waddr;
  logic                rd_in_store;

  assign item_ready = (state == S_IDLE);
  assign tick_go    = item_valid && item_ready && (item.op == OP_TICK);

  // A write outside the configured frame is dropped.
  assign wr_go = item_valid && item_ready && (item.op == OP_WRITE) &&
                 (ROWNUM_W'(item.row) <= LAST_ROW_N) &&
                 (COLNUM_W'(item.column) <= LAST_COL_N);
  assign waddr = {item.row, item.column};

  // Read address; entries beyond the writable store read as zero.
  assign rd_row_n    = ROWNUM_W'(cur_row);
  assign rd_col_n    = COLNUM_W'(rd_col);
  assign rd_in_store = (rd_row_n < STORE_ROWS) && (rd_col_n < STORE_COLS);
  assign raddr       = {rd_row_n[ROW_W-1:0], rd_col_n[COL_W-1:0]};

  assign out_free = !result_valid || result_ready;
  assign q_data   = q_ok ? mem_q : '0;
  assign wrap     = (cur_row == LAST_ROW_R);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_go) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (pix_done) state_next = S_CODE;
      end
      S_CODE: begin
        if (emit_code) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs. The read data register holds its value until the
  // column it carries has been used, so a stalled result side simply stops
  // further reads.
  always_comb begin
    take_first = 1'b0;
    consume    = 1'b0;
    emit_pix   = 1'b0;
    pix_done   = 1'b0;
    emit_code  = 1'b0;
    issue      = 1'b0;
    pix_byte   = {q_data[3:0], prev[7:4]};
    unique case (state)
      S_IDLE: begin
      end
      S_SCAN: begin
        if (!have_prev) begin
          take_first = q_vld;
          consume    = q_vld;
        end else if (emit_col == '0) begin
          // Column 0 has nothing below it to borrow a nibble from.
          emit_pix = out_free;
          pix_done = out_free;
          pix_byte = {4'h0, prev[7:4]};
        end else begin
          emit_pix = q_vld && out_free;
          consume  = emit_pix;
        end
        issue = reads_left && (!q_vld || consume);
      end
      S_CODE: begin
        emit_code = out_free;
      end
      default: begin
      end
    endcase
  end

  // Frame store array.
  always_ff @(posedge clk) begin
    if (wr_go) begin
      mem[waddr] <= item.value;
    end
    if (issue) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      q_ok    <= 1'b0;
    end else begin
      if (wr_go) mem_vld[waddr] <= 1'b1;
      if (issue) q_ok <= mem_vld[raddr] && rd_in_store;
    end
  end

  // Scan control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_row   <= '0;
      q_vld      <= 1'b0;
      have_prev  <= 1'b0;
      reads_left <= 1'b0;
    end else begin
      state <= state_next;
      if (tick_go) begin
        have_prev  <= 1'b0;
        reads_left <= 1'b1;
        q_vld      <= 1'b0;
      end else begin
        if (issue) begin
          q_vld <= 1'b1;
          if (rd_col == '0) reads_left <= 1'b0;
        end else if (consume) begin
          q_vld <= 1'b0;
        end
        if (take_first) have_prev <= 1'b1;
      end
      if (emit_code) begin
        scan_row <= wrap ? '0 : cur_row + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      cur_row  <= scan_row;
      rd_col   <= LAST_COL_C;
      emit_col <= LAST_COL_C;
    end else begin
      if (issue && rd_col != '0) rd_col <= rd_col - CW'(1);
      if (consume) begin
        prev <= q_data;
        if (!take_first) emit_col <= emit_col - CW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_pix || emit_code) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pix) begin
      result <= '{out_byte: pix_byte, is_row_code: 1'b0, last: 1'b0,
                  frame_end: 1'b0};
    end else if (emit_code) begin
      result <= '{out_byte: row_bcd(ROWNUM_W'(cur_row)), is_row_code: 1'b1,
                  last: 1'b1, frame_end: wrap};
    end
  end

  // Checks.
  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_row <= LAST_ROW_R)
    else $error("scan row beyond last row");

  a_last_is_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> result.is_row_code)
    else $error("last result is not the row code");

  a_fend_on_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> result.last)
    else $error("frame end away from last result");

  a_read_only_scan: assert property (@(posedge clk) disable iff (rst)
    q_vld |-> state == S_SCAN)
    else $error("read data pending outside a scan");

  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> state == S_SCAN && !have_prev)
    else $error("tick transfer did not start a scan");

endmodule

[dv/display_row_scan_engine_unit_test.sv]
// ----------------------------------------------------------------------------
// Display row scan engine testbench
// Fills the frame store and scans rows while both sides idle at random. A
// scoreboard class predicts every pixel byte and row code and checks the
// results in order.
// ----------------------------------------------------------------------------
module display_row_scan_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drse_pkg::*;

  // Geometry of the engine under test; the defaults of the block.
  localparam int ROW_BYTES = 8;
  localparam int LAST_ROW  = 15;
  localparam int NUM_ROWS  = LAST_ROW + 1;

  // Scoreboard: a private copy of the frame store and row counter, and the
  // queue of results that are owed by ticks already taken by the engine.
  class scan_scoreboard;
    logic [BYTE_W-1:0] pixels [NUM_ROWS][ROW_BYTES];
    int unsigned       scan_row;
    result_t           pending[$];
    int unsigned       errors;
    int unsigned       writes;
    int unsigned       ticks;
    int unsigned       frames;
    int unsigned       checked;

    function new();
      foreach (pixels[r, c]) pixels[r][c] = '0;
      scan_row = 0;
      errors   = 0;
      writes   = 0;
      ticks    = 0;
      frames   = 0;
      checked  = 0;
    endfunction

    // An accepted write updates the store; an accepted tick queues the pixel
    // bytes of the current row, last column first, then the row code.
    function void note_item(item_t it);
      int                c;
      int unsigned       r;
      logic [BYTE_W-1:0] b;
      result_t           res;
      if (it.op == OP_WRITE) begin
        writes++;
        if (it.row <= LAST_ROW && it.column < ROW_BYTES)
          pixels[it.row][it.column] = it.value;
        return;
      end
      ticks++;
      r = scan_row;
      for (c = ROW_BYTES - 1; c >= 0; c--) begin
        b = pixels[r][c] >> 4;
        if (c > 0)
          b = b | {pixels[r][c-1][3:0], 4'h0};
        res.out_byte    = b;
        res.is_row_code = 1'b0;
        res.last        = 1'b0;
        res.frame_end   = 1'b0;
        pending.push_back(res);
      end
      res.out_byte    = {4'(r / 10), 4'(r % 10)};
      res.is_row_code = 1'b1;
      res.last        = 1'b1;
      res.frame_end   = (r >= LAST_ROW);
      if (r >= LAST_ROW) begin
        scan_row = 0;
        frames++;
      end else begin
        scan_row = r + 1;
      end
      pending.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: out_byte=%02h is_row_code=%0d last=%0d frame_end=%0d",
               got.out_byte, got.is_row_code, got.last, got.frame_end);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.is_row_code !== want.is_row_code) begin
        $error("is_row_code: expected %0d, got %0d", want.is_row_code, got.is_row_code);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  // All block inputs start at known values before the first edge.
  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // When set, neither side idles, so back-to-back transfers are exercised.
  bit calm = 1'b0;

  scan_scoreboard sb = new();

  display_row_scan_engine_unit #(
    .ROW_BYTES(ROW_BYTES),
    .LAST_ROW (LAST_ROW)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Both channels are observed at the rising edge, before any register of the
  // edge updates. A result taken at the same edge as an item belongs to an
  // earlier tick, so it is checked before the new item is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        sb.check_result(result);
      if (item_valid && item_ready)
        sb.note_item(item);
    end
  end

  // Offers one item after a random gap and holds it until the engine takes it.
  // When no gap is drawn, valid stays high and only the payload changes.
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Holds the sender back until every queued result has come out. It waits on
  // the clock before checking the queue, so that the monitor has surely noted the last item taken.
  task automatic wait_for_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic item_t make_write(input logic [ROW_W-1:0] r,
                                       input logic [COL_W-1:0] c,
                                       input logic [BYTE_W-1:0] v);
    item_t it;
    it.op     = OP_WRITE;
    it.row    = r;
    it.column = c;
    it.value  = v;
    return it;
  endfunction

  // A tick carries random junk in the write fields, which the engine ignores.
  function automatic item_t make_tick();
    item_t it;
    it.op     = OP_TICK;
    it.row    = ROW_W'($urandom);
    it.column = COL_W'($urandom);
    it.value  = BYTE_W'($urandom);
    return it;
  endfunction

  // Result side: a random stall before each transfer, ready held until then.
  initial begin : result_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin : stimulus
    int                i;
    item_t             it;
    logic [BYTE_W-1:0] v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Row 0 gets bytes whose nibbles show the swap between
    // neighboring columns, including an all-ones byte at column 0, the edge
    // of the row. Rows 10 and 15 check the two-digit row code, and a
    // full frame of ticks reaches the wrap with frame_end.
    send_item(make_write(4'd0, 3'd7, 8'hF0));
    send_item(make_write(4'd0, 3'd6, 8'h0F));
    send_item(make_write(4'd0, 3'd1, 8'h5A));
    send_item(make_write(4'd0, 3'd0, 8'hFF));
    send_item(make_write(4'd1, 3'd3, 8'h81));
    send_item(make_write(4'd10, 3'd4, 8'hC3));
    send_item(make_write(4'd15, 3'd7, 8'hFF));
    send_item(make_write(4'd15, 3'd0, 8'h01));
    for (i = 0; i < NUM_ROWS; i++) begin
      it = make_tick();
      // Alternate the ignored fields between all ones and all zeros.
      if (i % 2 == 0) begin
        it.row    = '1;
        it.column = '1;
        it.value  = '1;
      end else begin
        it.row    = '0;
        it.column = '0;
        it.value  = '0;
      end
      send_item(it);
    end

    // Let the whole frame drain before the random part begins.
    wait_for_drain();

    // Random part: a mix of writes anywhere in the store and ticks, with
    // stretches of no idling and an occasional full drain.
    for (i = 0; i < 350; i++) begin
      if (i % 45 == 0)
        calm = ($urandom_range(0, 3) == 0);
      if (i % 90 == 89)
        wait_for_drain();
      if ($urandom_range(0, 99) < 55) begin
        case ($urandom_range(0, 7))
          0:       v = 8'h00;
          1:       v = 8'hFF;
          default: v = BYTE_W'($urandom);
        endcase
        send_item(make_write(ROW_W'($urandom), COL_W'($urandom), v));
      end else begin
        send_item(make_tick());
      end
    end
    calm = 1'b0;

    // Wait for the last results, then let the engine run on idle to
    // show any stray transfer.
    wait_for_drain();
    repeat (ROW_BYTES + 6) @(posedge clk);

    $display("Covered %0d frame writes and %0d row scans over %0d full frames.",
             sb.writes, sb.ticks, sb.frames);
    $display("Checked %0d results in order, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #(3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
rtl/drse_pkg.sv
rtl/display_row_scan_engine_unit.sv
dv/display_row_scan_engine_unit_test.sv
